/* hw/rtl/gri_pkg.sv */
package gri_pkg;

  // Field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned DB_W    = 16;
  localparam int unsigned LIM_W   = 24;
  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned RATE_W  = 19;

  // APB
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_STEP_TIME,
    REG_DEADBAND_RATE,
    REG_ANGLE_LIMIT
  } reg_idx_e;

  localparam logic [STEP_W-1:0] STEP_TIME_RST     = STEP_W'(328);
  localparam logic [DB_W-1:0]   DEADBAND_RATE_RST = DB_W'(256);
  localparam logic [LIM_W-1:0]  ANGLE_LIMIT_RST   = LIM_W'(2949120);
  localparam logic [LIM_W-1:0]  LIMIT_MAX         = LIM_W'(11796480);

  // Calibration block length
  localparam int unsigned CAL_SAMPLES = 100;
  localparam int unsigned CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;

  // 0.00875 dps/LSB in Q8 is 56/25
  localparam int unsigned SCALE_NUM = 56;
  localparam int unsigned SCALE_DEN = 25;

  // Round-to-nearest division: q = (2*m + d) / (2*d)
  localparam int unsigned RATE_DIV = 2 * SCALE_DEN;
  localparam int unsigned CAL_DIV  = 2 * SCALE_DEN * CAL_SAMPLES;
  localparam int unsigned DEN_W    = $clog2(CAL_DIV + 1);

  localparam int unsigned RAW_MAG_MAX = 2 ** (RAW_W - 1);
  localparam int unsigned SUM_MAG_MAX = CAL_SAMPLES * RAW_MAG_MAX;
  localparam int unsigned SUM_W       = $clog2(SUM_MAG_MAX + 1) + 1;

  localparam int unsigned RATE_NUM_MAX = RAW_MAG_MAX * 2 * SCALE_NUM + SCALE_DEN;
  localparam int unsigned CAL_NUM_MAX  = SUM_MAG_MAX * 2 * SCALE_NUM + SCALE_DEN * CAL_SAMPLES;
  localparam int unsigned RNUM_W       = $clog2(RATE_NUM_MAX + 1);
  localparam int unsigned NUM_W        = $clog2(CAL_NUM_MAX + 1);
  localparam int unsigned ITER_W       = $clog2(NUM_W + 1);

  localparam int unsigned Q_W    = $clog2(CAL_NUM_MAX / CAL_DIV + 1);
  localparam int unsigned BIAS_W = Q_W + 1;

  // Integration datapath
  localparam int unsigned MAG_W      = RATE_W - 1;
  localparam int unsigned PROD_W     = MAG_W + STEP_W;
  localparam int unsigned ROUND_SH   = 8;
  localparam int unsigned ROUND_HALF = 2 ** (ROUND_SH - 1);
  localparam int unsigned INC_W      = PROD_W + 1 - ROUND_SH;
  localparam int unsigned SUMA_W     = INC_W + 2;

endpackage

/* hw/rtl/gri_req_if.sv */
interface gri_req_if
  import gri_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [RAW_W-1:0] raw_rate;

  modport source (output valid, output req_type, output raw_rate, input ready);
  modport sink   (input valid, input req_type, input raw_rate, output ready);
endinterface

/* hw/rtl/gri_rsp_if.sv */
interface gri_rsp_if
  import gri_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_out;
  logic signed [RATE_W-1:0]  rate_out;
  logic                      in_deadband;
  logic                      cal_done;

  modport source (output valid, output angle_out, output rate_out, output in_deadband,
                  output cal_done, input ready);
  modport sink   (input valid, input angle_out, input rate_out, input in_deadband,
                  input cal_done, output ready);
endinterface

/* hw/rtl/gyro_rate_angle_integrator.sv */
// Channel   Dir  Handshake       Payload
// req_i     in   valid / ready   req_type, raw_rate
// rsp_o     out  valid / ready   angle_out, rate_out, in_deadband, cal_done
// apb       in   psel / penable  paddr, pwdata, pwrite (prdata back, pready tied high)
//
// One request at a time. An integrate step divides, removes the bias, checks the
// dead band and, outside it, multiplies, rounds, adds and clamps; a calibration
// sample is accumulated, and the sample that closes a block is divided into the new
// bias. The bit-serial divider (one quotient bit a cycle) and the bit-serial
// multiplier (one step_time bit a cycle) do the arithmetic. Reset clears angle, bias
// and calibration progress and loads the register defaults. A response waits in the
// output register while the sink stalls; the next request is taken once the result is in it.
module gyro_rate_angle_integrator
  import gri_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  gri_req_if.sink            req_i,
  gri_rsp_if.source          rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_DIV,
    ST_BIAS,
    ST_CORR,
    ST_DEAD,
    ST_MUL,
    ST_RND,
    ST_ADD,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] step_time_q;
  logic [DB_W-1:0]   deadband_rate_q;
  logic [LIM_W-1:0]  angle_limit_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q     <= STEP_TIME_RST;
      deadband_rate_q <= DEADBAND_RATE_RST;
      angle_limit_q   <= ANGLE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STEP_TIME:     step_time_q     <= pwdata[STEP_W-1:0];
        REG_DEADBAND_RATE: deadband_rate_q <= pwdata[DB_W-1:0];
        REG_ANGLE_LIMIT:   angle_limit_q   <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP_TIME:     prdata = PDATA_W'(step_time_q);
      REG_DEADBAND_RATE: prdata = PDATA_W'(deadband_rate_q);
      REG_ANGLE_LIMIT:   prdata = PDATA_W'(angle_limit_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and serial datapath
  // ---------------------------------------------------------------------------
  state_e                     state_q, state_d;
  logic                       type_q, type_d;         // 1: integrate step
  logic signed [RAW_W-1:0]    raw_q, raw_d;
  logic [NUM_W-1:0]           num_q, num_d;           // dividend in, quotient out
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic                       neg_q, neg_d;
  logic [ITER_W-1:0]          iter_q, iter_d;
  logic signed [RATE_W-1:0]   rate_q, rate_d;
  logic [MAG_W-1:0]           mag_q, mag_d;
  logic [STEP_W-1:0]          step_sh_q, step_sh_d;
  logic [PROD_W-1:0]          prod_q, prod_d;
  logic [INC_W-1:0]           inc_q, inc_d;
  logic signed [SUMA_W-1:0]   asum_q, asum_d;
  logic                       dead_q, dead_d;
  logic                       done_q, done_d;
  logic signed [ANGLE_W-1:0]  angle_q, angle_d;
  logic signed [BIAS_W-1:0]   bias_q, bias_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0]  out_angle_q, out_angle_d;
  logic signed [RATE_W-1:0]   out_rate_q, out_rate_d;
  logic                       out_dead_q, out_dead_d;
  logic                       out_done_q, out_done_d;

  // Combinational helpers
  logic [RAW_W-1:0]           raw_mag;
  logic [RNUM_W-1:0]          rate_num;
  logic signed [SUM_W-1:0]    sum_new;
  logic [SUM_W-2:0]           sum_mag;
  logic [CNT_W:0]             cnt_inc;
  logic [DEN_W-1:0]           den;
  logic [DEN_W:0]             trial;
  logic [Q_W-1:0]             quot;
  logic signed [BIAS_W-1:0]   quot_b;
  logic signed [RATE_W-1:0]   quot_r;
  logic [MAG_W-1:0]           rate_abs;
  logic [PROD_W:0]            prod_rnd;
  logic signed [SUMA_W-1:0]   inc_ext;
  logic [LIM_W-1:0]           lim;
  logic signed [SUMA_W-1:0]   lim_s;
  logic                       out_free;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.angle_out   = out_angle_q;
  assign rsp_o.rate_out    = out_rate_q;
  assign rsp_o.in_deadband = out_dead_q;
  assign rsp_o.cal_done    = out_done_q;

  always_comb begin
    // Integrate dividend: |raw|*112 + 25, to be divided by 50
    raw_mag  = req_i.raw_rate[RAW_W-1] ? RAW_W'(-req_i.raw_rate) : RAW_W'(req_i.raw_rate);
    rate_num = RNUM_W'(RNUM_W'(raw_mag) * RNUM_W'(2 * SCALE_NUM)) + RNUM_W'(SCALE_DEN);

    // Calibration accumulate
    sum_new = sum_q + SUM_W'(raw_q);
    sum_mag = sum_new[SUM_W-1] ? (SUM_W-1)'(-sum_new) : (SUM_W-1)'(sum_new);
    cnt_inc = {1'b0, cnt_q} + (CNT_W+1)'(1);

    // One restoring-division step
    den   = type_q ? DEN_W'(RATE_DIV) : DEN_W'(CAL_DIV);
    trial = {rem_q, num_q[NUM_W-1]};
    quot  = num_q[Q_W-1:0];
    quot_b = BIAS_W'(quot);
    quot_r = RATE_W'(quot);

    rate_abs = rate_q[RATE_W-1] ? MAG_W'(-rate_q) : MAG_W'(rate_q);
    prod_rnd = {1'b0, prod_q} + (PROD_W+1)'(ROUND_HALF);
    inc_ext  = SUMA_W'(inc_q);
    lim      = (angle_limit_q > LIMIT_MAX) ? LIMIT_MAX : angle_limit_q;
    lim_s    = SUMA_W'(lim);

    out_free = !out_valid_q || rsp_o.ready;
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    raw_d       = raw_q;
    num_d       = num_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    iter_d      = iter_q;
    rate_d      = rate_q;
    mag_d       = mag_q;
    step_sh_d   = step_sh_q;
    prod_d      = prod_q;
    inc_d       = inc_q;
    asum_d      = asum_q;
    dead_d      = dead_q;
    done_d      = done_q;
    angle_d     = angle_q;
    bias_d      = bias_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_angle_d = out_angle_q;
    out_rate_d  = out_rate_q;
    out_dead_d  = out_dead_q;
    out_done_d  = out_done_q;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          type_d = req_i.req_type;
          raw_d  = req_i.raw_rate;
          if (req_i.req_type) begin
            // Left-align the short dividend so the quotient lands in the low bits
            num_d   = NUM_W'(rate_num) << (NUM_W - RNUM_W);
            neg_d   = req_i.raw_rate[RAW_W-1];
            rem_d   = '0;
            iter_d  = ITER_W'(RNUM_W);
            state_d = ST_DIV;
          end else begin
            state_d = ST_CAL;
          end
        end
      end

      ST_CAL: begin
        rate_d = '0;
        dead_d = 1'b0;
        if (cnt_inc >= (CNT_W+1)'(CAL_SAMPLES)) begin
          // Block complete: divide |sum|*112 + 25*N by 50*N
          num_d   = NUM_W'(NUM_W'(sum_mag) * NUM_W'(2 * SCALE_NUM))
                  + NUM_W'(SCALE_DEN * CAL_SAMPLES);
          neg_d   = sum_new[SUM_W-1];
          rem_d   = '0;
          iter_d  = ITER_W'(NUM_W);
          sum_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          sum_d   = sum_new;
          cnt_d   = cnt_inc[CNT_W-1:0];
          done_d  = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DIV: begin
        if (trial >= {1'b0, den}) begin
          rem_d = DEN_W'(trial - {1'b0, den});
          num_d = {num_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = DEN_W'(trial);
          num_d = {num_q[NUM_W-2:0], 1'b0};
        end
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          state_d = type_q ? ST_CORR : ST_BIAS;
        end
      end

      ST_BIAS: begin
        bias_d  = neg_q ? -quot_b : quot_b;
        done_d  = 1'b1;
        state_d = ST_DONE;
      end

      ST_CORR: begin
        // Apply sign, remove the learnt bias
        rate_d  = (neg_q ? -quot_r : quot_r) - RATE_W'(bias_q);
        state_d = ST_DEAD;
      end

      ST_DEAD: begin
        mag_d  = rate_abs;
        done_d = 1'b0;
        if (rate_abs < MAG_W'(deadband_rate_q)) begin
          dead_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          dead_d    = 1'b0;
          step_sh_d = step_time_q;
          prod_d    = '0;
          iter_d    = ITER_W'(STEP_W);
          state_d   = ST_MUL;
        end
      end

      ST_MUL: begin
        // Shift-and-add, step_time MSB first
        prod_d    = {prod_q[PROD_W-2:0], 1'b0}
                  + (step_sh_q[STEP_W-1] ? PROD_W'(mag_q) : PROD_W'(0));
        step_sh_d = {step_sh_q[STEP_W-2:0], 1'b0};
        iter_d    = iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          state_d = ST_RND;
        end
      end

      ST_RND: begin
        inc_d   = prod_rnd[PROD_W:ROUND_SH];
        state_d = ST_ADD;
      end

      ST_ADD: begin
        asum_d  = rate_q[RATE_W-1] ? SUMA_W'(angle_q) - inc_ext : SUMA_W'(angle_q) + inc_ext;
        state_d = ST_CLAMP;
      end

      ST_CLAMP: begin
        if (asum_q > lim_s) begin
          angle_d = ANGLE_W'(lim_s);
        end else if (asum_q < -lim_s) begin
          angle_d = ANGLE_W'(-lim_s);
        end else begin
          angle_d = ANGLE_W'(asum_q);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_angle_d = angle_q;
          out_rate_d  = rate_q;
          out_dead_d  = dead_q;
          out_done_d  = done_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      type_q      <= 1'b0;
      raw_q       <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      iter_q      <= '0;
      rate_q      <= '0;
      mag_q       <= '0;
      step_sh_q   <= '0;
      prod_q      <= '0;
      inc_q       <= '0;
      asum_q      <= '0;
      dead_q      <= 1'b0;
      done_q      <= 1'b0;
      angle_q     <= '0;
      bias_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_angle_q <= '0;
      out_rate_q  <= '0;
      out_dead_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      raw_q       <= raw_d;
      num_q       <= num_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      iter_q      <= iter_d;
      rate_q      <= rate_d;
      mag_q       <= mag_d;
      step_sh_q   <= step_sh_d;
      prod_q      <= prod_d;
      inc_q       <= inc_d;
      asum_q      <= asum_d;
      dead_q      <= dead_d;
      done_q      <= done_d;
      angle_q     <= angle_d;
      bias_q      <= bias_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_angle_q <= out_angle_d;
      out_rate_q  <= out_rate_d;
      out_dead_q  <= out_dead_d;
      out_done_q  <= out_done_d;
    end
  end

endmodule

/* dv/testbench.sv */
module testbench
  import gri_pkg::*;
();

  // Request kinds carried on req_type
  localparam logic REQ_CAL       = 1'b0;
  localparam logic REQ_INTEGRATE = 1'b1;

  // 0.00875 dps per LSB expressed in Q8 is exactly 56/25
  localparam longint SCALE_N = 56;
  localparam longint SCALE_D = 25;

  // Longest correct gap without any handshake is an integrate step plus a
  // sink stall; give it a wide margin
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Quiet time after the last response, a little over the slowest latency
  localparam int unsigned SETTLE_CYCLES  = 60;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  rate;
    logic                      dead;
    logic                      done;
  } angle_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gri_req_if req_if ();
  gri_rsp_if rsp_if ();

  gyro_rate_angle_integrator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers
  logic [STEP_W-1:0]         cfg_step;
  logic [DB_W-1:0]           cfg_deadband;
  logic [LIM_W-1:0]          cfg_limit;
  // Shadow copy of the integrator state
  logic signed [ANGLE_W-1:0] trk_angle;
  logic signed [31:0]        trk_bias;
  logic signed [23:0]        trk_cal_sum;
  int unsigned               trk_cal_cnt;

  // Responses forecast for requests already handed to the block, oldest first
  angle_rsp_t  angle_rsp_due_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned n_cal        = 0;
  int unsigned n_int        = 0;
  int unsigned n_dead       = 0;
  int unsigned n_bias_upd   = 0;
  int unsigned n_reg_wr     = 0;

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch, %s", $time, what);
    end
  endfunction

  // Round to nearest, ties away from zero; den is always positive
  function automatic longint div_nearest(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic void reset_shadow();
    cfg_step     = STEP_TIME_RST;
    cfg_deadband = DEADBAND_RATE_RST;
    cfg_limit    = ANGLE_LIMIT_RST;
    trk_angle    = '0;
    trk_bias     = '0;
    trk_cal_sum  = '0;
    trk_cal_cnt  = 0;
  endfunction

  // Advance the shadow state by one request and queue the response it must produce
  function automatic void forecast_angle_rsp(input logic kind,
                                             input logic signed [RAW_W-1:0] raw);
    angle_rsp_t res;
    longint     rate;
    longint     mag;
    longint     lim;
    longint     inc;
    longint     ang;
    res  = '{default: '0};
    rate = 0;
    if (kind == REQ_CAL) begin
      // Accumulate; the block of samples closes into a new bias
      trk_cal_sum = trk_cal_sum + raw;
      trk_cal_cnt++;
      if (trk_cal_cnt >= CAL_SAMPLES) begin
        trk_bias    = 32'(div_nearest(longint'(trk_cal_sum) * SCALE_N,
                                      SCALE_D * longint'(CAL_SAMPLES)));
        trk_cal_sum = '0;
        trk_cal_cnt = 0;
        res.done    = 1'b1;
      end
    end else begin
      rate = div_nearest(longint'(raw) * SCALE_N, SCALE_D) - longint'(trk_bias);
      mag  = (rate < 0) ? -rate : rate;
      if (mag < longint'(cfg_deadband)) begin
        // Inside the dead band: angle held, no clamp either
        res.dead = 1'b1;
      end else begin
        // A limit beyond the angle range behaves as the range itself
        lim = (cfg_limit > LIMIT_MAX) ? longint'(LIMIT_MAX) : longint'(cfg_limit);
        inc = (mag * longint'(cfg_step) + 128) / 256;
        ang = longint'(trk_angle) + ((rate < 0) ? -inc : inc);
        if (ang > lim) ang = lim;
        if (ang < -lim) ang = -lim;
        trk_angle = ANGLE_W'(ang);
      end
    end
    res.angle = trk_angle;
    res.rate  = RATE_W'(rate);
    angle_rsp_due_q.push_back(res);
  endfunction

  // Offer one request, idling first at the current sender rate. Valid stays high
  // afterwards so a following request can go out without a gap.
  task automatic send_req(input logic kind, input logic signed [RAW_W-1:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.raw_rate <= raw;
    forecast_angle_rsp(kind, raw);
    if (kind == REQ_CAL) n_cal++;
    else n_int++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drop valid and hold off until every forecast response has been seen
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (angle_rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then an idle cycle
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // The register takes the value at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_STEP_TIME:     cfg_step     = val[STEP_W-1:0];
      REG_DEADBAND_RATE: cfg_deadband = val[DB_W-1:0];
      REG_ANGLE_LIMIT:   cfg_limit    = val[LIM_W-1:0];
      default: ;
    endcase
    n_reg_wr++;
    @(posedge clk_i);
  endtask

  // APB read; prdata is sampled in the access cycle
  task automatic check_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      note_mismatch($sformatf("register %s read: expected 0x%0h, got 0x%0h",
                              idx.name(), want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all three registers and read them back; only call while the block is idle
  task automatic set_config(input logic [PDATA_W-1:0] step, input logic [PDATA_W-1:0] dead,
                            input logic [PDATA_W-1:0] lim);
    write_reg(REG_STEP_TIME, step);
    write_reg(REG_DEADBAND_RATE, dead);
    write_reg(REG_ANGLE_LIMIT, lim);
    check_reg(REG_STEP_TIME, PDATA_W'(cfg_step));
    check_reg(REG_DEADBAND_RATE, PDATA_W'(cfg_deadband));
    check_reg(REG_ANGLE_LIMIT, PDATA_W'(cfg_limit));
  endtask

  // Pick a setting, often at an extreme
  task automatic load_random_config();
    logic [PDATA_W-1:0] step;
    logic [PDATA_W-1:0] dead;
    logic [PDATA_W-1:0] lim;
    case ($urandom_range(3))
      0:       step = 1;
      1:       step = 16'hFFFF;
      default: step = $urandom_range(4000, 1);
    endcase
    case ($urandom_range(4))
      0:       dead = 0;
      1:       dead = $urandom_range(16'hFFFF);
      default: dead = $urandom_range(2000);
    endcase
    case ($urandom_range(3))
      0:       lim = 0;
      1:       lim = $urandom_range(24'hFFFFFF, LIMIT_MAX);
      default: lim = $urandom_range(LIMIT_MAX);
    endcase
    set_config(step, dead, lim);
  endtask

  // Mostly realistic traffic: runs of calibration samples and of integrate steps, each
  // around its own random base, with full-scale noise and the odd pause until the pipe is empty
  task automatic run_traffic(input int unsigned n_items);
    int unsigned             sent;
    int unsigned             len;
    int unsigned             pick;
    int                      base;
    logic signed [RAW_W-1:0] raw;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      base = int'($urandom_range(4000)) - 2000;
      if (pick < 30) begin
        len = $urandom_range(80, 10);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) send_req(REQ_CAL, RAW_W'(base + int'($urandom_range(128)) - 64));
        sent += len;
      end else if (pick < 85) begin
        len = $urandom_range(30, 3);
        if (len > n_items - sent) len = n_items - sent;
        repeat (len) begin
          if ($urandom_range(3) == 0) raw = RAW_W'($urandom);
          else raw = RAW_W'(base + int'($urandom_range(2000)) - 1000);
          send_req(REQ_INTEGRATE, raw);
        end
        sent += len;
      end else if (pick < 97) begin
        send_req($urandom_range(1) ? REQ_INTEGRATE : REQ_CAL, RAW_W'($urandom));
        sent++;
      end else begin
        wait_drain();
      end
    end
  endtask

  // Reset values, then writes with junk in the bits above each register's width
  task automatic test_register_access();
    check_reg(REG_STEP_TIME, PDATA_W'(STEP_TIME_RST));
    check_reg(REG_DEADBAND_RATE, PDATA_W'(DEADBAND_RATE_RST));
    check_reg(REG_ANGLE_LIMIT, PDATA_W'(ANGLE_LIMIT_RST));
    set_config({16'hA5A5, STEP_TIME_RST}, {16'h5A5A, DEADBAND_RATE_RST},
               {8'hC3, ANGLE_LIMIT_RST});
  endtask

  // Default setting, no bias learnt yet: full-scale samples, both sides of the
  // dead band edge, and calibration samples mixed in
  task automatic test_uncalibrated_extremes();
    send_req(REQ_INTEGRATE, 16'h7FFF);
    send_req(REQ_INTEGRATE, 16'h8000);
    send_req(REQ_INTEGRATE, 16'h0000);
    send_req(REQ_INTEGRATE, 16'h0001);
    send_req(REQ_INTEGRATE, 16'hFFFF);
    send_req(REQ_INTEGRATE, 16'sd114);   // rounds to 255, just inside the dead band
    send_req(REQ_INTEGRATE, 16'sd115);   // rounds to 258, just outside
    send_req(REQ_INTEGRATE, -16'sd115);
    send_req(REQ_CAL, 16'h7FFF);
    send_req(REQ_CAL, 16'h8000);
    send_req(REQ_INTEGRATE, 16'h7FFF);
  endtask

  // Saturation at the full range, a limit lowered beneath the angle, zero step
  // time and a zero limit
  task automatic test_saturation_and_limits();
    wait_drain();
    set_config(16'hFFFF, 0, 32'hFFFF_FFFF);
    send_req(REQ_INTEGRATE, 16'h7FFF);
    send_req(REQ_INTEGRATE, 16'h7FFF);
    send_req(REQ_INTEGRATE, 16'h8000);
    send_req(REQ_INTEGRATE, 16'h8000);
    // Angle now sits beyond the new limit; dead-band steps and samples must not clamp
    wait_drain();
    set_config(16'hFFFF, 16'hFFFF, 32'h0001_0000);
    send_req(REQ_INTEGRATE, 16'sd1000);
    send_req(REQ_CAL, 16'sd5);
    // Zero increment still clamps
    wait_drain();
    set_config(0, 0, 32'h0001_0000);
    send_req(REQ_INTEGRATE, 16'sd0);
    wait_drain();
    set_config(0, 0, 0);
    send_req(REQ_INTEGRATE, 16'sd7);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned n_items);
    wait_drain();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    load_random_config();
    run_traffic(n_items / 2);
    wait_drain();
    load_random_config();
    run_traffic(n_items - n_items / 2);
  endtask

  // Response sink: stall at the current receiver rate
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare every accepted response with the oldest forecast
  always @(posedge clk_i) begin : check_rsp
    angle_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (angle_rsp_due_q.size() == 0) begin
        note_mismatch("response with no request outstanding");
      end else begin
        want = angle_rsp_due_q.pop_front();
        if (want.angle !== rsp_if.angle_out)
          note_mismatch($sformatf("angle_out: expected %0d, got %0d",
                                  want.angle, rsp_if.angle_out));
        if (want.rate !== rsp_if.rate_out)
          note_mismatch($sformatf("rate_out: expected %0d, got %0d",
                                  want.rate, rsp_if.rate_out));
        if (want.dead !== rsp_if.in_deadband)
          note_mismatch($sformatf("in_deadband: expected %0b, got %0b",
                                  want.dead, rsp_if.in_deadband));
        if (want.done !== rsp_if.cal_done)
          note_mismatch($sformatf("cal_done: expected %0b, got %0b",
                                  want.done, rsp_if.cal_done));
        if (want.dead) n_dead++;
        if (want.done) n_bias_upd++;
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", stall_cycles);
      $display("FAIL gyro_rate_angle_integrator");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_CAL;
    req_if.raw_rate <= '0;
    reset_shadow();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under a slow sender and a heavily stalling receiver
    src_idle_pct = 31;
    snk_idle_pct = 80;
    test_register_access();
    test_uncalibrated_extremes();
    test_saturation_and_limits();

    // Random part: swap the idling sides, then run flat out
    test_random_traffic(31, 80, 280);
    test_random_traffic(80, 31, 280);
    test_random_traffic(0, 0, 280);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (angle_rsp_due_q.size() != 0) begin
      note_mismatch($sformatf("%0d responses never arrived", angle_rsp_due_q.size()));
    end
    $display("covered %0d calibration samples (%0d bias updates) and %0d integrate steps",
             n_cal, n_bias_upd, n_int);
    $display("%0d steps held in the dead band, %0d register writes, %0d mismatches",
             n_dead, n_reg_wr, mismatches);
    if (mismatches == 0) begin
      $display("PASS gyro_rate_angle_integrator");
    end else begin
      $display("FAIL gyro_rate_angle_integrator");
    end
    $finish;
  end

endmodule
